>>> hdl/mm2h_pkg.sv
package mm2h_pkg;

    localparam int unsigned WordW     = 32;
    localparam int unsigned ByteW     = 8;
    localparam int unsigned TailW     = 24;
    localparam int unsigned TailCntW  = 2;
    localparam int unsigned QueueDepthDefault = 2;

    localparam logic [WordW-1:0] MixMul = 32'h5bd1e995;
    localparam int unsigned WordShift = 24;
    localparam int unsigned FinShiftA = 13;
    localparam int unsigned FinShiftB = 15;

    localparam logic [TailCntW-1:0] CntFull = 2'd3;

    // One job for the back end: start value, an optional whole word, an
    // optional finish with its tail.
    typedef struct packed {
        logic                start;
        logic [WordW-1:0]    init;
        logic                word_valid;
        logic [WordW-1:0]    word;
        logic                last;
        logic [TailW-1:0]    tail;
        logic [TailCntW-1:0] tail_cnt;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WK1,
        ST_WK2,
        ST_WH,
        ST_FT,
        ST_FA,
        ST_FO
    } t_back_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_K,
        OP_K_SHR,
        OP_H,
        OP_H_TAIL,
        OP_H_SHR
    } t_mul_op;

    function automatic logic [WordW-1:0] mul_m(input logic [WordW-1:0] a);
        logic [WordW-1:0] p;
        p = a * MixMul;
        return p;
    endfunction

endpackage

>>> hdl/mm2h_if.sv
interface mm2h_in_if import mm2h_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ByteW-1:0]    data_byte;
    logic                first_of_message;
    logic                last_of_message;
    logic [WordW-1:0]    msg_length;

    modport source (output valid, output data_byte, output first_of_message,
                    output last_of_message, output msg_length, input ready);
    modport sink   (input valid, input data_byte, input first_of_message,
                    input last_of_message, input msg_length, output ready);
endinterface

interface mm2h_out_if import mm2h_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WordW-1:0]    hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

>>> hdl/mm2h_front.sv
module mm2h_front import mm2h_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [WordW-1:0] i_cfg_wdata,
    mm2h_in_if.sink          i_in,
    input  t_q_stat          i_q_stat,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic [WordW-1:0]    r_seed;
    logic [TailW-1:0]    r_pend, n_pend;
    logic [TailCntW-1:0] r_cnt, n_cnt;

    logic                accept;
    logic                empty_msg;
    logic [TailW-1:0]    eff_pend;
    logic [TailCntW-1:0] eff_cnt;
    logic                word_v;
    logic [WordW-1:0]    word;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign empty_msg  = i_in.first_of_message && i_in.last_of_message
                        && (i_in.msg_length == '0);

    always_comb begin
        eff_pend = i_in.first_of_message ? '0 : r_pend;
        eff_cnt  = i_in.first_of_message ? '0 : r_cnt;
        word_v   = 1'b0;
        word     = {i_in.data_byte, eff_pend};
        n_pend   = eff_pend;
        n_cnt    = eff_cnt;
        if (!empty_msg) begin
            if (eff_cnt == CntFull) begin
                word_v = 1'b1;
                n_pend = '0;
                n_cnt  = '0;
            end else begin
                case (eff_cnt)
                    2'd0:    n_pend = {eff_pend[23:8],  i_in.data_byte};
                    2'd1:    n_pend = {eff_pend[23:16], i_in.data_byte, eff_pend[7:0]};
                    default: n_pend = {i_in.data_byte, eff_pend[15:0]};
                endcase
                n_cnt = eff_cnt + 2'd1;
            end
        end
    end

    always_comb begin
        o_cmd.start      = i_in.first_of_message;
        o_cmd.init       = r_seed ^ i_in.msg_length;
        o_cmd.word_valid = word_v;
        o_cmd.word       = word;
        o_cmd.last       = i_in.last_of_message;
        o_cmd.tail       = n_pend;
        o_cmd.tail_cnt   = n_cnt;
        o_push = accept && (i_in.first_of_message || word_v || i_in.last_of_message);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_pend <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (accept) begin
                // drop pending bytes once a message closes
                r_pend <= i_in.last_of_message ? '0 : n_pend;
                r_cnt  <= i_in.last_of_message ? '0 : n_cnt;
            end
        end
    end

endmodule

>>> hdl/mm2h_queue.sv
module mm2h_queue import mm2h_pkg::*; #(
    parameter int unsigned DEPTH = QueueDepthDefault
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntMax  = CntW'(DEPTH);

    t_cmd            r_mem [DEPTH];
    logic [PtrW-1:0] r_wptr, r_rptr;
    logic [CntW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_stat.full  = (r_count == CntMax);
    assign o_stat.empty = (r_count == '0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PtrLast) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PtrLast) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/mm2h_back.sv
module mm2h_back import mm2h_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_q_stat i_q_stat,
    output logic    o_pop,
    mm2h_out_if.source o_out
);

    t_back_state         r_state, n_state;
    logic [WordW-1:0]    r_h;
    logic [WordW-1:0]    r_k;
    logic                r_last;
    logic [TailW-1:0]    r_tail;
    logic [TailCntW-1:0] r_tail_cnt;
    logic                r_out_valid;
    logic [WordW-1:0]    r_out_hash;

    t_mul_op             mul_op;
    logic [WordW-1:0]    mul_a;
    logic [WordW-1:0]    mul_p;
    logic                out_free;

    assign out_free         = !r_out_valid || o_out.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_out_hash;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    if (i_cmd.word_valid) begin
                        n_state = ST_WK1;
                    end else if (i_cmd.last) begin
                        n_state = (i_cmd.tail_cnt != '0) ? ST_FT : ST_FA;
                    end
                end
            end
            ST_WK1: n_state = ST_WK2;
            ST_WK2: n_state = ST_WH;
            ST_WH: begin
                if (r_last) begin
                    n_state = (r_tail_cnt != '0) ? ST_FT : ST_FA;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_FT: n_state = ST_FA;
            ST_FA: n_state = ST_FO;
            ST_FO: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs: pop and multiplier operand
    always_comb begin
        o_pop  = 1'b0;
        mul_op = OP_NONE;
        case (r_state)
            ST_IDLE: o_pop  = !i_q_stat.empty;
            ST_WK1:  mul_op = OP_K;
            ST_WK2:  mul_op = OP_K_SHR;
            ST_WH:   mul_op = OP_H;
            ST_FT:   mul_op = OP_H_TAIL;
            ST_FA:   mul_op = OP_H_SHR;
            default: mul_op = OP_NONE;
        endcase
    end

    always_comb begin
        case (mul_op)
            OP_K:      mul_a = r_k;
            OP_K_SHR:  mul_a = r_k ^ (r_k >> WordShift);
            OP_H:      mul_a = r_h;
            OP_H_TAIL: mul_a = r_h ^ {8'd0, r_tail};
            OP_H_SHR:  mul_a = r_h ^ (r_h >> FinShiftA);
            default:   mul_a = '0;
        endcase
        mul_p = mul_m(mul_a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_h         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // load a new result beat, else drop the one just taken
            if ((r_state == ST_FO) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_q_stat.empty && i_cmd.start) begin
                        r_h <= i_cmd.init;
                    end
                end
                ST_WH:   r_h <= mul_p ^ r_k;
                ST_FT:   r_h <= mul_p;
                ST_FA:   r_h <= mul_p;
                ST_FO: begin
                    if (out_free) begin
                        r_h <= '0;
                    end
                end
                default: r_h <= r_h;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_k        <= i_cmd.word;
                r_last     <= i_cmd.last;
                r_tail     <= i_cmd.tail;
                r_tail_cnt <= i_cmd.tail_cnt;
            end
            ST_WK1, ST_WK2: r_k <= mul_p;
            ST_FO: begin
                if (out_free) begin
                    r_out_hash <= r_h ^ (r_h >> FinShiftB);
                end
            end
            default: r_k <= r_k;
        endcase
    end

endmodule

>>> hdl/murmur2_byte_stream_hash.sv
// MurmurHash2, 32-bit, over a stream of bytes, one byte per input beat. The
// first beat of a message carries its total length; the hash starts as the
// seed register XOR that length. Every fourth byte closes a little-endian word,
// and the beat marked last closes the message: leftover bytes are mixed in as
// the tail, the final avalanche runs and one result beat carries the hash. An
// empty message is a single beat with first and last set and length zero. The
// front end packs bytes into words and takes one beat per cycle while its job
// queue has room; the back end shares a single 32x32 constant multiplier
// among all its steps. A word takes a fetch plus three multiplies, so a stream
// of whole words is sustained at one byte per cycle; the first beat of a
// message adds a fetch of its own. Closing a message runs the avalanche and
// output steps after a final whole word, with a fetch first when the last job
// carries no word (and a tail step when tail bytes are mixed in); the result
// beat is registered from the output step, which waits while an earlier result
// beat is still held. Write the seed only while no message is in flight.
module murmur2_byte_stream_hash import mm2h_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [WordW-1:0] i_cfg_wdata,
    mm2h_in_if.sink          i_in,
    mm2h_out_if.source       o_out
);

    logic    push, pop;
    t_cmd    push_cmd, head_cmd;
    t_q_stat q_stat;

    // accept, classify and pack bytes into jobs
    mm2h_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // hold jobs so either side may stall on its own
    mm2h_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    // mix words, finish and deliver the result beat
    mm2h_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (head_cmd),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

>>> test/tb_murmur2_byte_stream_hash.sv
`timescale 1ns / 100ps

module tb_murmur2_byte_stream_hash;
    import mm2h_pkg::*;

    // Clock, reset and the seed register port
    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [WordW-1:0] cfg_wdata;

    mm2h_in_if  in_if ();
    mm2h_out_if out_if ();

    murmur2_byte_stream_hash dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // 10 ns period, high then low
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Our own copy of the seed and of the message state, updated on every
    // accepted input beat.
    logic [WordW-1:0]    seed_copy     = '0;
    logic [WordW-1:0]    running_h     = '0;
    logic [TailW-1:0]    tail_bytes    = '0;
    logic [TailCntW-1:0] tail_cnt      = '0;

    // Finished hashes still owed by the block, oldest first
    logic [WordW-1:0] hash_due_q[$];

    int unsigned mismatches     = 0;
    int unsigned hashes_checked = 0;
    int unsigned bytes_sent     = 0;
    int unsigned in_stall_beats = 0;
    int unsigned seeds_written  = 0;

    // Percentages of cycles in which the sender idles and the receiver stalls
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    // Cycles left in a forced receiver hold-off
    int unsigned hold_left = 0;

    // Absorb one accepted beat into the predicted state; on the last beat of
    // a message, run the tail and the avalanche and queue the finished hash.
    task automatic murmur_absorb_beat(input logic [ByteW-1:0] b, input logic first,
                                      input logic last, input logic [WordW-1:0] len);
        logic [WordW-1:0] k;
        logic [WordW-1:0] h;
        if (first) begin
            running_h  = seed_copy ^ len;
            tail_bytes = '0;
            tail_cnt   = '0;
        end
        // An empty message carries a byte that must not be hashed
        if (!(first && last && len == '0)) begin
            if (tail_cnt == CntFull) begin
                // Fourth byte closes a little-endian word
                k = {b, tail_bytes};
                k = k * MixMul;
                k = k ^ (k >> WordShift);
                k = k * MixMul;
                running_h  = (running_h * MixMul) ^ k;
                tail_bytes = '0;
                tail_cnt   = '0;
            end else begin
                tail_bytes = tail_bytes | (TailW'(b) << (ByteW * tail_cnt));
                tail_cnt   = tail_cnt + 1'b1;
            end
        end
        if (last) begin
            h = running_h;
            if (tail_cnt != '0) begin
                h = h ^ WordW'(tail_bytes);
                h = h * MixMul;
            end
            h = h ^ (h >> FinShiftA);
            h = h * MixMul;
            h = h ^ (h >> FinShiftB);
            hash_due_q.push_back(h);
            running_h  = '0;
            tail_bytes = '0;
            tail_cnt   = '0;
        end
    endtask

    // Receiver: drive ready at the falling edge, honouring any hold-off first
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            out_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Check every result beat against the oldest owed hash
    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            if (hash_due_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, got %08h",
                         $time, out_if.hash_value);
            end else begin
                if (out_if.hash_value !== hash_due_q[0]) begin
                    mismatches++;
                    $display("%0t: hash_value mismatch, expected %08h, got %08h",
                             $time, hash_due_q[0], out_if.hash_value);
                end
                void'(hash_due_q.pop_front());
                hashes_checked++;
            end
        end
        // Count input beats held back by the block
        if (rst_n && in_if.valid && !in_if.ready)
            in_stall_beats++;
    end

    // Offer one beat; hold it until the block takes it, then predict.
    task automatic send_byte(input logic [ByteW-1:0] b, input logic first,
                             input logic last, input logic [WordW-1:0] len);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            // Idle cycle: drop valid and scribble on the payload
            in_if.valid     <= 1'b0;
            in_if.data_byte <= ByteW'($urandom);
            @(negedge clk);
        end
        in_if.valid            <= 1'b1;
        in_if.data_byte        <= b;
        in_if.first_of_message <= first;
        in_if.last_of_message  <= last;
        in_if.msg_length       <= len;
        do @(posedge clk); while (!in_if.ready);
        murmur_absorb_beat(b, first, last, len);
        bytes_sent++;
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_if.valid <= 1'b0;
    endtask

    // Send n random bytes; the length field counts only on the first beat.
    // Zero bytes means an empty message: one beat, first and last, length 0.
    task automatic send_message(input int unsigned n_bytes, input logic [WordW-1:0] len_field,
                                input logic with_first, input logic with_last);
        int unsigned i;
        if (n_bytes == 0) begin
            send_byte(ByteW'($urandom), 1'b1, 1'b1, '0);
            return;
        end
        for (i = 0; i < n_bytes; i++)
            send_byte(ByteW'($urandom), with_first && i == 0, with_last && i == n_bytes - 1,
                      (i == 0) ? len_field : WordW'($urandom));
    endtask

    // Wait for every owed hash, with a guard; anything left over is a failure
    task automatic wait_hashes_drained();
        int unsigned guard;
        guard = 0;
        while (hash_due_q.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        if (hash_due_q.size() != 0) begin
            mismatches += hash_due_q.size();
            $display("%0t: %0d hash(es) never arrived, next expected %08h, got nothing",
                     $time, hash_due_q.size(), hash_due_q[0]);
            hash_due_q.delete();
        end
    endtask

    // Write the seed only once the block is quiet: all hashes in, then a
    // pause covering the back end's latency.
    task automatic write_seed(input logic [WordW-1:0] value);
        wait_hashes_drained();
        repeat (12) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        seed_copy = value;
        seeds_written++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Directed beats under the reset seed: bytes with no first beat, empty
    // message, single bytes, whole words, every tail size, lengths that
    // disagree with the bytes sent, and field extremes.
    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        // No first beat straight after reset: continue from a zero hash
        send_byte(8'h00, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_byte(8'hFF, 1'b0, 1'b1, 32'h0000_0000);
        // Empty message; its byte must be ignored
        send_byte(8'hA5, 1'b1, 1'b1, 32'h0000_0000);
        // Single byte, first and last on one beat
        send_byte(8'hFF, 1'b1, 1'b1, 32'h0000_0001);
        // One byte but a length claiming more
        send_byte(8'h00, 1'b1, 1'b1, 32'h0000_0005);
        // Exactly one word, no tail
        send_byte(8'hFF, 1'b1, 1'b0, 32'h0000_0004);
        send_byte(8'h00, 1'b0, 1'b0, 32'h8000_0000);
        send_byte(8'hFF, 1'b0, 1'b0, 32'h0000_0000);
        send_byte(8'h01, 1'b0, 1'b1, 32'hFFFF_FFFF);
        // Three-byte tail with the largest length
        send_byte(8'h80, 1'b1, 1'b0, 32'hFFFF_FFFF);
        send_byte(8'h7F, 1'b0, 1'b0, 32'h0000_0000);
        send_byte(8'hFF, 1'b0, 1'b1, 32'h0000_0000);
        // Word plus a one-byte tail
        send_byte(8'h12, 1'b1, 1'b0, 32'h0000_0005);
        send_byte(8'h34, 1'b0, 1'b0, 32'h0000_0000);
        send_byte(8'h56, 1'b0, 1'b0, 32'h0000_0000);
        send_byte(8'h78, 1'b0, 1'b0, 32'h0000_0000);
        send_byte(8'h9A, 1'b0, 1'b1, 32'h0000_0000);
        // Two bytes with length zero on the first beat: both still absorbed
        send_byte(8'hC3, 1'b1, 1'b0, 32'h0000_0000);
        send_byte(8'h3C, 1'b0, 1'b1, 32'h0000_0000);
        // Lone last beat after a finished message
        send_byte(8'h5A, 1'b0, 1'b1, 32'h1234_5678);
        drop_valid();
        wait_hashes_drained();
    endtask

    // One random message: mostly well formed and short, some long; the rest
    // are lengths that disagree, messages with no first beat and messages
    // abandoned before their last beat (the next first restarts the hash).
    task automatic send_random_message();
        int unsigned kind;
        int unsigned pick;
        int unsigned n;
        kind = $urandom_range(99);
        pick = $urandom_range(99);
        n = (pick < 80) ? $urandom_range(8) :
            (pick < 95) ? $urandom_range(32, 9) : $urandom_range(64, 33);
        if (kind < 80)
            send_message(n, n, 1'b1, 1'b1);
        else if (kind < 88)
            send_message((n == 0) ? 1 : n, $urandom_range(1) ? '0 : WordW'($urandom),
                         1'b1, 1'b1);
        else if (kind < 94)
            send_message(n + 1, WordW'($urandom), 1'b0, 1'b1);
        else
            send_message(n + 1, WordW'(n + 1 + $urandom_range(5)), 1'b1, 1'b0);
    endtask

    // One phase of random traffic under a given seed and idling mix; close
    // with a well-formed message so nothing is left open.
    task automatic run_phase(input int unsigned idle, input int unsigned stall,
                             input logic [WordW-1:0] seed, input int unsigned n_items);
        int unsigned start;
        write_seed(seed);
        idle_pct  = idle;
        stall_pct = stall;
        start = bytes_sent;
        while (bytes_sent - start < n_items)
            send_random_message();
        send_message(4, 32'd4, 1'b1, 1'b1);
        drop_valid();
        wait_hashes_drained();
    endtask

    // Random traffic across the idling mixes and seed extremes
    task automatic test_random_traffic();
        run_phase(0, 0, 32'hFFFF_FFFF, 120);
        run_phase(70, 0, WordW'($urandom), 120);
        run_phase(0, 70, 32'h0000_0000, 120);
        run_phase(29, 29, WordW'($urandom), 120);
    endtask

    // Hold the receiver off for a long stretch while the sender keeps
    // offering beats, so results pile up and the input stalls.
    task automatic test_output_backpressure();
        write_seed(WordW'($urandom));
        idle_pct  = 0;
        stall_pct = 0;
        @(posedge clk);
        hold_left = 120;
        send_message(2, 32'd2, 1'b1, 1'b1);
        send_message(0, 32'd0, 1'b1, 1'b1);
        send_message(1, 32'd1, 1'b1, 1'b1);
        send_message(3, 32'd3, 1'b1, 1'b1);
        send_message(24, 32'd24, 1'b1, 1'b1);
        drop_valid();
        wait_hashes_drained();
    endtask

    // Pause the sender until every hash is in, then carry on
    task automatic test_drain_pause();
        idle_pct  = 10;
        stall_pct = 10;
        send_message(7, 32'd7, 1'b1, 1'b1);
        drop_valid();
        wait_hashes_drained();
        send_message(9, 32'd9, 1'b1, 1'b1);
        send_message(4, 32'd4, 1'b1, 1'b1);
        drop_valid();
        wait_hashes_drained();
    endtask

    initial begin
        // Known values on every input from time zero
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        in_if.valid            = 1'b0;
        in_if.data_byte        = '0;
        in_if.first_of_message = 1'b0;
        in_if.last_of_message  = 1'b0;
        in_if.msg_length       = '0;
        out_if.ready           = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_traffic();
        test_output_backpressure();
        test_drain_pause();

        // Leave time for any stray result beat to show up
        wait_hashes_drained();
        repeat (20) @(posedge clk);

        $display("Covered %0d bytes and %0d hashes over %0d seed writes and four idle mixes;",
                 bytes_sent, hashes_checked, seeds_written);
        $display("input held back on %0d cycles, including a long result hold-off.",
                 in_stall_beats);
        if (mismatches == 0)
            $display("tb_murmur2_byte_stream_hash: done, clean");
        else
            $display("tb_murmur2_byte_stream_hash: done, errors");
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #2000000;
        $display("%0t: run timed out", $time);
        $display("tb_murmur2_byte_stream_hash: done, errors");
        $finish;
    end

endmodule
